// ===== src/ecal_pkg.sv =====
`timescale 1ns / 1ps

package ecal_pkg;

	localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
	localparam int          DIV60_SHIFT = 37;
	localparam logic [21:0] DIV24_MAGIC = 22'd2796203;
	localparam int          DIV24_SHIFT = 26;
	localparam logic [16:0] DIV7_MAGIC  = 17'd74899;
	localparam int          DIV7_SHIFT  = 19;
	localparam logic [11:0] YEAR_MAGIC  = 12'd2870;
	localparam int          YEAR_SHIFT  = 20;
	localparam logic [7:0]  YEAR_2100   = 8'd130;

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [15:0] days;
	} tod_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [7:0] year_offset;
		logic [3:0] month;
		logic [4:0] day_of_month;
	} cal_t;

	// leap years in range: year_offset % 4 == 2 (1972, 1976, ...), except 2100
	function automatic logic is_leap(input logic [7:0] yr);
		return (yr[1:0] == 2'd2) && (yr != YEAR_2100);
	endfunction

	// day count at january 1 of the given year offset
	function automatic logic [15:0] year_start(input logic [7:0] yr);
		logic [8:0]  yp1;
		logic [15:0] base;
		logic [15:0] leaps;
		yp1   = {1'b0, yr} + 9'd1;
		base  = 16'(yr) * 16'd365;
		leaps = 16'(yp1[8:2]);
		if (yr > YEAR_2100) begin
			leaps = leaps - 16'd1;
		end
		return base + leaps;
	endfunction

	// day of year at the first of month m (0 is january)
	function automatic logic [8:0] mon_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		unique case (m)
			4'd0:  s = 9'd0;
			4'd1:  s = 9'd31;
			4'd2:  s = 9'd59;
			4'd3:  s = 9'd90;
			4'd4:  s = 9'd120;
			4'd5:  s = 9'd151;
			4'd6:  s = 9'd181;
			4'd7:  s = 9'd212;
			4'd8:  s = 9'd243;
			4'd9:  s = 9'd273;
			4'd10: s = 9'd304;
			4'd11: s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && m >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

// ===== src/ecal_if.sv =====
`timescale 1ns / 1ps

interface ecal_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source(output valid, output epoch_seconds, input ready);
	modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [2:0] weekday;
	logic [7:0] year_offset;
	logic [3:0] month;
	logic [4:0] day_of_month;

	modport source(output valid, output second, output minute, output hour,
		output weekday, output year_offset, output month, output day_of_month,
		input ready);
	modport sink(input valid, input second, input minute, input hour,
		input weekday, input year_offset, input month, input day_of_month,
		output ready);
endinterface

// ===== src/ecal_time_split.sv =====
`timescale 1ns / 1ps

module ecal_time_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        epoch_seconds,
	output logic               valid_s3,
	output ecal_pkg::tod_t     tod_s3
);

	logic        valid_s1, valid_s2;
	logic [26:0] mins_s1;
	logic [5:0]  sec_s1;
	logic [20:0] hours_s2;
	logic [5:0]  sec_s2, min_s2;

	logic [63:0] prod1, prod2;
	logic [43:0] prod3;
	logic [26:0] q1;
	logic [20:0] q2;
	logic [15:0] q3;
	logic [31:0] r1;
	logic [26:0] r2;
	logic [20:0] r3;

	// seconds -> minutes
	assign prod1 = 64'(epoch_seconds) * 64'(ecal_pkg::DIV60_MAGIC);
	assign q1    = prod1[ecal_pkg::DIV60_SHIFT +: 27];
	assign r1    = epoch_seconds - 32'(q1) * 32'd60;

	// minutes -> hours
	assign prod2 = 64'(mins_s1) * 64'(ecal_pkg::DIV60_MAGIC);
	assign q2    = prod2[ecal_pkg::DIV60_SHIFT +: 21];
	assign r2    = mins_s1 - 27'(q2) * 27'd60;

	// hours -> days
	assign prod3 = 44'(hours_s2) * 44'(ecal_pkg::DIV24_MAGIC);
	assign q3    = prod3[ecal_pkg::DIV24_SHIFT +: 16];
	assign r3    = hours_s2 - 21'(q3) * 21'd24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mins_s1       <= q1;
			sec_s1        <= r1[5:0];
			hours_s2      <= q2;
			sec_s2        <= sec_s1;
			min_s2        <= r2[5:0];
			tod_s3.second <= sec_s2;
			tod_s3.minute <= min_s2;
			tod_s3.hour   <= r3[4:0];
			tod_s3.days   <= q3;
		end
	end

endmodule

// ===== src/ecal_date.sv =====
`timescale 1ns / 1ps

module ecal_date (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ecal_pkg::tod_t     tod,
	output logic               valid_s6,
	output ecal_pkg::cal_t     cal_s6
);

	logic           valid_s4, valid_s5;
	ecal_pkg::tod_t tod_s4;
	logic [16:0]    wx_s4;
	logic [12:0]    q7_s4;
	logic [7:0]     est_s4;
	logic [5:0]     sec_s5, min_s5;
	logic [4:0]     hour_s5;
	logic [2:0]     wday_s5;
	logic [7:0]     year_s5;
	logic [8:0]     doy_s5;
	logic           leap_s5;

	logic [16:0] wx;
	logic [33:0] prod7;
	logic [27:0] prody;
	logic [7:0]  est_n;
	logic [15:0] start_n, start_c;
	logic        ge;
	logic [7:0]  year;
	logic [15:0] doy;
	logic [16:0] wr;
	logic [3:0]  mi;
	logic [8:0]  dom;

	// weekday divide and year estimate
	assign wx    = 17'(tod.days) + 17'd3;
	assign prod7 = 34'(wx) * 34'(ecal_pkg::DIV7_MAGIC);
	assign prody = 28'(tod.days) * 28'(ecal_pkg::YEAR_MAGIC);

	// estimate is the year or one below
	assign est_n   = est_s4 + 8'd1;
	assign start_n = ecal_pkg::year_start(est_n);
	assign start_c = ecal_pkg::year_start(est_s4);
	assign ge      = (tod_s4.days >= start_n);
	assign year    = ge ? est_n : est_s4;
	assign doy     = tod_s4.days - (ge ? start_n : start_c);
	assign wr      = wx_s4 - 17'(q7_s4) * 17'd7;

	// month search over the start table
	always_comb begin
		mi = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (doy_s5 >= ecal_pkg::mon_start(4'(m), leap_s5)) begin
				mi = mi + 4'd1;
			end
		end
	end
	assign dom = doy_s5 - ecal_pkg::mon_start(mi, leap_s5) + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tod_s4              <= tod;
			wx_s4               <= wx;
			q7_s4               <= prod7[ecal_pkg::DIV7_SHIFT +: 13];
			est_s4              <= prody[ecal_pkg::YEAR_SHIFT +: 8];
			sec_s5              <= tod_s4.second;
			min_s5              <= tod_s4.minute;
			hour_s5             <= tod_s4.hour;
			wday_s5             <= wr[2:0] + 3'd1;
			year_s5             <= year;
			doy_s5              <= doy[8:0];
			leap_s5             <= ecal_pkg::is_leap(year);
			cal_s6.second       <= sec_s5;
			cal_s6.minute       <= min_s5;
			cal_s6.hour         <= hour_s5;
			cal_s6.weekday      <= wday_s5;
			cal_s6.year_offset  <= year_s5;
			cal_s6.month        <= mi + 4'd1;
			cal_s6.day_of_month <= dom[4:0];
		end
	end

endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps

// epoch seconds to calendar date converter
// req: valid/ready channel carrying a 32-bit count of seconds since
//   1970-01-01 00:00:00; a request is taken when valid and ready are high
// rsp: valid/ready channel carrying second, minute, hour, weekday
//   (1 = monday), year_offset (year - 1970), month and day_of_month
// every request gives exactly one response
// throughput: one request per cycle while rsp is not stalled; the six register
//   stages hold the constant-multiply divides and the compare and subtract steps
// reset: all stage valid bits clear, rsp.valid is low, req.ready is high
// stall: when rsp.valid is high and rsp.ready is low the whole pipeline
//   holds and req.ready drops; nothing is lost or repeated
module epoch_seconds_to_calendar (
	input logic          clk,
	input logic          arst_n,
	ecal_in_if.sink      req,
	ecal_out_if.source   rsp
);

	logic           en;
	logic           tod_valid;
	ecal_pkg::tod_t tod;
	logic           cal_valid;
	ecal_pkg::cal_t cal;

	assign en        = !cal_valid || rsp.ready;
	assign req.ready = en;

	ecal_time_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (req.valid),
		.epoch_seconds (req.epoch_seconds),
		.valid_s3      (tod_valid),
		.tod_s3        (tod)
	);

	ecal_date u_date (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (tod_valid),
		.tod      (tod),
		.valid_s6 (cal_valid),
		.cal_s6   (cal)
	);

	assign rsp.valid        = cal_valid;
	assign rsp.second       = cal.second;
	assign rsp.minute       = cal.minute;
	assign rsp.hour         = cal.hour;
	assign rsp.weekday      = cal.weekday;
	assign rsp.year_offset  = cal.year_offset;
	assign rsp.month        = cal.month;
	assign rsp.day_of_month = cal.day_of_month;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	bit hold_rsp = 1'b0;
	ecal_pkg::cal_t date_q[$];

	ecal_in_if req();
	ecal_out_if rsp();

	epoch_seconds_to_calendar DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #2 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.epoch_seconds = '0;
		rsp.ready = 1'b0;
	end

	function automatic bit year_is_leap(input int unsigned yoff);
		int unsigned y;
		y = 1970 + yoff;
		if (y % 4 != 0) return 1'b0;
		if (y % 100 != 0) return 1'b1;
		return y % 400 == 0;
	endfunction

	function automatic ecal_pkg::cal_t calendar_of(input logic [31:0] secs);
		int unsigned t, days, yr, m, mlen, ylen;
		int unsigned mlens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		ecal_pkg::cal_t c;
		t = secs;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		days = t / 24;
		c.weekday = 3'(((days + 3) % 7) + 1);
		yr = 0;
		forever begin
			ylen = year_is_leap(yr) ? 366 : 365;
			if (days < ylen) break;
			days -= ylen;
			yr++;
		end
		m = 0;
		while (m < 11) begin
			mlen = (m == 1) ? (year_is_leap(yr) ? 29 : 28) : mlens[m];
			if (days < mlen) break;
			days -= mlen;
			m++;
		end
		c.year_offset = 8'(yr);
		c.month = 4'(m + 1);
		c.day_of_month = 5'(days + 1);
		return c;
	endfunction

	task automatic send_request(input logic [31:0] secs, input bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.epoch_seconds <= secs;
		do @(posedge clk); while (!req.ready);
		date_q.push_back(calendar_of(secs));
	endtask

	// response side: random stalls, or a long hold when asked
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_rsp = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		ecal_pkg::cal_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (date_q.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				e = date_q.pop_front();
				if (rsp.second !== e.second) begin
					$error("second exp %0d got %0d", e.second, rsp.second); errors++;
				end
				if (rsp.minute !== e.minute) begin
					$error("minute exp %0d got %0d", e.minute, rsp.minute); errors++;
				end
				if (rsp.hour !== e.hour) begin
					$error("hour exp %0d got %0d", e.hour, rsp.hour); errors++;
				end
				if (rsp.weekday !== e.weekday) begin
					$error("weekday exp %0d got %0d", e.weekday, rsp.weekday); errors++;
				end
				if (rsp.year_offset !== e.year_offset) begin
					$error("year_offset exp %0d got %0d", e.year_offset, rsp.year_offset);
					errors++;
				end
				if (rsp.month !== e.month) begin
					$error("month exp %0d got %0d", e.month, rsp.month); errors++;
				end
				if (rsp.day_of_month !== e.day_of_month) begin
					$error("day_of_month exp %0d got %0d", e.day_of_month, rsp.day_of_month);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [31:0] v[$] = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd3599, 32'd86399, 32'd86400,
			32'd68169600, 32'd68256000, 32'd951782400, 32'd951868800, 32'd946684799,
			32'd4107456000, 32'd4107542400, 32'd4102444799, 32'd4133894400,
			32'd4133980799, 32'd1234567890, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hAAAA_AAAA, 32'h5555_5555};
		foreach (v[i]) send_request(v[i]);
	endtask

	task automatic test_random();
		for (int i = 0; i < 750; i++) send_request($urandom());
	endtask

	task automatic test_year_edges();
		int unsigned d, y;
		for (int i = 0; i < 60; i++) begin
			y = $urandom_range(0, 135);
			d = 0;
			for (int k = 0; k < y + 1; k++) d += year_is_leap(k) ? 366 : 365;
			d = d - $urandom_range(0, 1);
			send_request(32'(d * 86400 + $urandom_range(0, 86399)));
		end
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		for (int i = 0; i < 30; i++) send_request($urandom(), 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_year_edges();
		test_random();
		req.valid <= 1'b0;
		while (date_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/ecal_pkg.sv
src/ecal_if.sv
src/ecal_time_split.sv
src/ecal_date.sv
src/epoch_seconds_to_calendar.sv
tb/sv/tb_top.sv
